[rtl/ille_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ille_pkg
// Shared field widths, request and status codes, controller states and the
// command/status structs between the linked list controller and datapath.
// ----------------------------------------------------------------------------
package ille_pkg;

    localparam int REQ_W    = 2;
    localparam int POS_W    = 8;
    localparam int ITEM_W   = 32;
    localparam int RD_W     = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET    = 2'd0,
        REQ_SET    = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_REMOVE = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_NODE,
        S_INS_NEW,
        S_INS_NBR,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_CHECK,
        DP_WALK,
        DP_SET,
        DP_INS_NEW,
        DP_INS_NBR,
        DP_REMOVE,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
        logic    ret;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic in_range;
        logic empty_ok;
        logic full;
        logic step_hit;
    } t_dp_stat;

endpackage
`default_nettype wire

[rtl/ille_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ille_ctrl
// Request sequencer: bounds check, list walk, link update steps and result
// issue. Drives the datapath through one command per cycle.
// ----------------------------------------------------------------------------
module ille_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ille_pkg::t_dp_stat i_stat,
    output ille_pkg::t_dp_cmd       o_cmd
);
    import ille_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_ret    <= n_ret;
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_ret        = r_ret;
        o_cmd.op     = DP_NONE;
        o_cmd.status = r_status;
        o_cmd.ret    = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = DP_LATCH;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.op = DP_CHECK;
                n_ret    = 1'b0;
                if (!i_stat.in_range) begin
                    // out of range: only an insert at position zero into an empty list goes on
                    if (i_stat.req == REQ_INSERT && i_stat.empty_ok) begin
                        n_status = ST_OK;
                        n_state  = S_INS_NEW;
                    end else begin
                        n_status = ST_OOB;
                        n_state  = S_DONE;
                    end
                end else if (i_stat.req == REQ_INSERT && i_stat.full) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.op = DP_WALK;
                if (i_stat.step_hit) begin
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                unique case (i_stat.req)
                    REQ_GET: begin
                        n_ret   = 1'b1;
                        n_state = S_DONE;
                    end
                    REQ_SET: begin
                        o_cmd.op = DP_SET;
                        n_state  = S_DONE;
                    end
                    REQ_INSERT: begin
                        n_state = S_INS_NEW;
                    end
                    REQ_REMOVE: begin
                        o_cmd.op = DP_REMOVE;
                        n_ret    = 1'b1;
                        n_state  = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INS_NEW: begin
                o_cmd.op = DP_INS_NEW;
                n_state  = S_INS_NBR;
            end
            S_INS_NBR: begin
                o_cmd.op = DP_INS_NBR;
                n_state  = S_DONE;
            end
            S_DONE: begin
                o_cmd.op = DP_EMIT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

[rtl/ille_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ille_dp
// Node store (value, next and prev memories), free node stack, list head,
// element count, walk registers and the result register.
// ----------------------------------------------------------------------------
module ille_dp #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ille_pkg::t_dp_cmd             i_cmd,
    output ille_pkg::t_dp_stat                 o_stat,
    input  wire logic [ille_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [ille_pkg::POS_W-1:0]    i_position,
    input  wire logic [ille_pkg::ITEM_W-1:0]   i_item_value,
    output logic                               o_done,
    output logic [ille_pkg::RD_W-1:0]          o_read_value,
    output logic [ille_pkg::STATUS_W-1:0]      o_status,
    output logic [ille_pkg::LEN_W-1:0]         o_list_length
);
    import ille_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam int RB = (VALUE_BITS < RD_W) ? VALUE_BITS : RD_W;
    localparam int IB = (VALUE_BITS < ITEM_W) ? VALUE_BITS : ITEM_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

    logic [VALUE_BITS-1:0] r_value_mem [CAPACITY];
    logic [LW-1:0]         r_next_mem  [CAPACITY];
    logic [LW-1:0]         r_prev_mem  [CAPACITY];
    logic [IW-1:0]         r_free_mem  [CAPACITY];

    t_req                  r_req;
    logic [POS_W-1:0]      r_pos;
    logic [VALUE_BITS-1:0] r_val;
    logic [LW-1:0]         r_cur;
    logic [POS_W-1:0]      r_step;
    logic                  r_follow;
    logic                  r_empty;
    logic [LW-1:0]         r_head;
    logic [LW-1:0]         r_count;
    logic [LW-1:0]         r_hwm;
    logic [LW-1:0]         r_fcnt;
    logic [VALUE_BITS-1:0] r_q_value;
    logic [LW-1:0]         r_q_next;
    logic [LW-1:0]         r_q_prev;
    logic [IW-1:0]         r_free_q;
    logic                  r_o_done;
    logic [RD_W-1:0]       r_o_value;
    t_status               r_o_status;
    logic [LEN_W-1:0]      r_o_len;

    logic [LW-1:0] n_cur;
    logic [LW-1:0] fcnt_dec;
    logic [IW-1:0] new_node;
    logic [LW-1:0] new_link;
    logic          prev_valid;
    logic          next_valid;
    logic [RD_W-1:0] rd_value;

    // follow the link just read, except on the first step from the head
    assign n_cur      = r_follow ? r_q_next : r_cur;
    assign fcnt_dec   = r_fcnt - LW'(1);
    // reuse a freed node first, otherwise take one never used
    assign new_node   = (r_fcnt != '0) ? r_free_q : r_hwm[IW-1:0];
    assign new_link   = LW'(new_node);
    assign prev_valid = (r_q_prev != NULL_LINK);
    assign next_valid = (r_q_next != NULL_LINK);
    assign rd_value   = RD_W'(r_q_value[RB-1:0]);

    always_comb begin
        o_stat.req      = r_req;
        o_stat.in_range = (CW'(r_pos) < CW'(r_count));
        o_stat.empty_ok = (r_pos == '0) && (r_count == '0);
        o_stat.full     = (r_count == LW'(CAPACITY));
        o_stat.step_hit = (r_step == r_pos);
    end

    // node store writes
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_SET: begin
                r_value_mem[r_cur[IW-1:0]] <= r_val;
            end
            DP_INS_NEW: begin
                r_value_mem[new_node] <= r_val;
                r_next_mem[new_node]  <= r_empty ? NULL_LINK : r_cur;
                r_prev_mem[new_node]  <= r_empty ? NULL_LINK : r_q_prev;
            end
            DP_INS_NBR: begin
                if (!r_empty) begin
                    if (prev_valid) begin
                        r_next_mem[r_q_prev[IW-1:0]] <= new_link;
                    end
                    r_prev_mem[r_cur[IW-1:0]] <= new_link;
                end
            end
            DP_REMOVE: begin
                if (prev_valid) begin
                    r_next_mem[r_q_prev[IW-1:0]] <= r_q_next;
                end
                if (next_valid) begin
                    r_prev_mem[r_q_next[IW-1:0]] <= r_q_prev;
                end
                r_free_mem[r_fcnt[IW-1:0]] <= r_cur[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    // node store reads: hold the last node read once the walk ends
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_WALK) begin
            r_q_value <= r_value_mem[n_cur[IW-1:0]];
            r_q_next  <= r_next_mem[n_cur[IW-1:0]];
            r_q_prev  <= r_prev_mem[n_cur[IW-1:0]];
        end
        r_free_q <= r_free_mem[fcnt_dec[IW-1:0]];
    end

    // list bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= NULL_LINK;
            r_count  <= '0;
            r_hwm    <= '0;
            r_fcnt   <= '0;
            r_o_done <= 1'b0;
        end else begin
            r_o_done <= (i_cmd.op == DP_EMIT);
            case (i_cmd.op)
                DP_INS_NEW: begin
                    if (r_empty || !prev_valid) begin
                        r_head <= new_link;
                    end
                end
                DP_INS_NBR: begin
                    r_count <= r_count + LW'(1);
                    if (r_fcnt != '0) begin
                        r_fcnt <= fcnt_dec;
                    end else begin
                        r_hwm <= r_hwm + LW'(1);
                    end
                end
                DP_REMOVE: begin
                    if (!prev_valid) begin
                        r_head <= r_q_next;
                    end
                    r_count <= r_count - LW'(1);
                    r_fcnt  <= r_fcnt + LW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // request and walk registers, result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_req <= t_req'(i_req_type);
                r_pos <= i_position;
                r_val <= VALUE_BITS'(i_item_value[IB-1:0]);
            end
            DP_CHECK: begin
                r_cur    <= r_head;
                r_step   <= '0;
                r_follow <= 1'b0;
                r_empty  <= (r_count == '0);
            end
            DP_WALK: begin
                r_cur    <= n_cur;
                r_step   <= r_step + POS_W'(1);
                r_follow <= 1'b1;
            end
            DP_EMIT: begin
                r_o_value  <= i_cmd.ret ? rd_value : '0;
                r_o_status <= i_cmd.status;
                r_o_len    <= LEN_W'(r_count);
            end
            default: begin
            end
        endcase
    end

    assign o_done        = r_o_done;
    assign o_read_value  = r_o_value;
    assign o_status      = r_o_status;
    assign o_list_length = r_o_len;

endmodule
`default_nettype wire

[rtl/indexed_linked_list_engine_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_linked_list_engine_core
// Doubly linked list in a fixed node store with get, set, insert-before and
// remove at a list position.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with i_req_type, i_position and i_item_value; the transaction
//   is taken at a clock edge where start is high and busy is low. busy stays
//   high until the request is finished, and one result follows per request.
//   o_done marks the result and is high for exactly one cycle; the result
//   stays on o_read_value, o_status and o_list_length until the next one.
//   The receiver has no way to hold it. Steps, with P the position:
//   out of bounds or store full: latch, check, result issue
//   get, set, remove:            latch, check, walk to P, node, result issue
//   insert:                      latch, check, walk to P, node, new node,
//                                neighbour links, result issue; an empty
//                                list skips the walk and the node step.
//   A new request can be taken in the cycle that shows o_done. The walk
//   from the head, one node-store read per position, takes the bulk of a
//   request's time.
// Reset: i_rst_n low empties the list at once; no clearing pass runs and the
//   node store contents stay as they were.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine_core #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ille_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [ille_pkg::POS_W-1:0]    i_position,
    input  wire logic [ille_pkg::ITEM_W-1:0]   i_item_value,
    output logic                               o_done,
    output logic [ille_pkg::RD_W-1:0]          o_read_value,
    output logic [ille_pkg::STATUS_W-1:0]      o_status,
    output logic [ille_pkg::LEN_W-1:0]         o_list_length
);
    import ille_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ille_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    ille_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_req_type    (i_req_type),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_done        (o_done),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_list_length (o_list_length)
    );

endmodule
`default_nettype wire

[rtl/ille_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ille_checker
// Port-level checks on the linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ille_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_done,
    input wire logic [ille_pkg::RD_W-1:0]     o_read_value,
    input wire logic [ille_pkg::STATUS_W-1:0] o_status
);
    import ille_pkg::*;

    // a taken transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    // a result shows only once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result issued while busy");

    // one strobe per transaction, never two in a row
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // failed requests return zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_read_value == '0))
        else $error("nonzero data with an error status");

endmodule

bind indexed_linked_list_engine_core ille_checker u_ille_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);
`default_nettype wire
